@@ hw/rtl/okvt_pkg.sv @@
// Package for the ordered key-value table: sizes, request and status codes,
// and the command struct broadcast to the cell chain. No dependencies.
package okvt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned VALUE_WIDTH = 32;

  // Port field widths
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned WVAL_W   = 32;
  localparam int unsigned RVAL_W   = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned ECOUNT_W = 5;
  localparam int unsigned STATUS_W = 2;

  // Internal widths
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef logic [KEY_WIDTH-1:0]   key_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET    = 3'd0,
    REQ_SET    = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_ACCESS = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Lookup key plus the update decided for this transaction
  typedef struct packed {
    key_t   key;
    value_t wr_value;
    logic   shift_en;
    logic   append_en;
    logic   set_en;
  } cell_cmd_t;

endpackage

@@ hw/rtl/okvt_req_if.sv @@
// Request channel interface of the ordered key-value table.
// Uses field widths from okvt_pkg.
interface okvt_req_if;
  logic                        valid;
  logic                        ready;
  logic [okvt_pkg::REQ_W-1:0]  req_type;
  logic [okvt_pkg::KEY_W-1:0]  key;
  logic [okvt_pkg::WVAL_W-1:0] write_value;

  modport source (output valid, req_type, key, write_value, input ready);
  modport sink   (input valid, req_type, key, write_value, output ready);
endinterface

@@ hw/rtl/okvt_rsp_if.sv @@
// Response channel interface of the ordered key-value table.
// Uses field widths from okvt_pkg.
interface okvt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [okvt_pkg::RVAL_W-1:0]   read_value;
  logic [okvt_pkg::POS_W-1:0]    position;
  logic [okvt_pkg::ECOUNT_W-1:0] entry_count;
  logic [okvt_pkg::STATUS_W-1:0] status;

  modport source (output valid, found, read_value, position, entry_count, status,
                  input ready);
  modport sink   (input valid, found, read_value, position, entry_count, status,
                  output ready);
endinterface

@@ hw/rtl/okvt_cell.sv @@
// One entry of the ordered key-value table: key and value registers, match
// logic and the hand-down path to its lower neighbor. Depends on okvt_pkg.
module okvt_cell (
  input  logic                clk_i,
  input  okvt_pkg::cell_cmd_t cmd_i,
  input  logic                used_i,     // entry lies below the fill count
  input  logic                tail_i,     // entry is the next free slot
  input  logic                hit_i,      // some lower-index entry matched
  input  okvt_pkg::key_t      next_key_i,
  input  okvt_pkg::value_t    next_val_i,
  output logic                hit_o,
  output logic                first_o,
  output okvt_pkg::key_t      key_o,
  output okvt_pkg::value_t    val_o
);

  okvt_pkg::key_t   key_q, key_d;
  okvt_pkg::value_t val_q, val_d;
  logic             match;

  assign match   = used_i && (key_q == cmd_i.key);
  assign first_o = match && !hit_i;
  assign hit_o   = hit_i || match;
  assign key_o   = key_q;
  assign val_o   = val_q;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    priority if (cmd_i.shift_en && hit_o) begin
      // close the gap left by the deleted entry
      key_d = next_key_i;
      val_d = next_val_i;
    end else if (cmd_i.append_en && tail_i) begin
      key_d = cmd_i.key;
      val_d = cmd_i.wr_value;
    end else if (cmd_i.set_en && first_o) begin
      val_d = cmd_i.wr_value;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

endmodule

@@ hw/rtl/ordered_key_value_table_top.sv @@
// Top level of the ordered key-value table: a chain of okvt_cell entries,
// the fill count and the response register. Depends on okvt_pkg and the
// okvt_req_if / okvt_rsp_if interfaces.
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------------
//   req_i    | in        | req_type, key, write_value
//   rsp_o    | out       | found, read_value, position, entry_count, status
//
// All cells compare the key at once, the first match ripples along the
// hit chain, and the update (set, append or shift-down on delete) lands
// at the same edge that loads the response register.
// Reset clears the fill count and the response valid; entries are not cleared.
// A new request is taken while the response register is empty or being
// drained, so a stalled response holds the request side for as long as the
// stall lasts.
module ordered_key_value_table_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  okvt_req_if.sink          req_i,
  okvt_rsp_if.source        rsp_o
);

  localparam int unsigned N = okvt_pkg::TABLE_DEPTH;

  okvt_pkg::cnt_t      count_q, count_d;
  okvt_pkg::cell_cmd_t cmd;
  okvt_pkg::req_e      req;
  logic                accept;

  logic [N:0]              hit_chain;
  logic [N-1:0]            first;
  logic [N-1:0]            used;
  logic [N-1:0]            tail;
  okvt_pkg::key_t          cell_key [N];
  okvt_pkg::value_t        cell_val [N];
  okvt_pkg::key_t          next_key [N];
  okvt_pkg::value_t        next_val [N];

  okvt_pkg::value_t        hit_val;
  okvt_pkg::idx_t          hit_idx;
  logic                    found;
  logic                    full;
  logic                    is_set;
  logic                    is_access;

  logic                    rsp_valid_q;
  logic                    found_q, found_d;
  okvt_pkg::value_t        rval_q, rval_d;
  okvt_pkg::idx_t          pos_q, pos_d;
  okvt_pkg::status_e       status_q, status_d;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign req         = okvt_pkg::req_e'(req_i.req_type);
  assign is_set      = (req == okvt_pkg::REQ_SET);
  assign is_access   = (req == okvt_pkg::REQ_ACCESS);
  assign full        = (count_q == okvt_pkg::cnt_t'(N));

  assign hit_chain[0] = 1'b0;
  assign found        = hit_chain[N];

  assign cmd.key       = okvt_pkg::key_t'(req_i.key);
  assign cmd.wr_value  = is_set ? okvt_pkg::value_t'(req_i.write_value) : '0;
  assign cmd.shift_en  = accept && (req == okvt_pkg::REQ_DELETE) && found;
  assign cmd.append_en = accept && (is_set || is_access) && !found && !full;
  assign cmd.set_en    = accept && is_set && found;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign used[i] = okvt_pkg::cnt_t'(i) < count_q;
    assign tail[i] = okvt_pkg::cnt_t'(i) == count_q;
    if (i == N - 1) begin : g_last
      assign next_key[i] = cell_key[i];
      assign next_val[i] = cell_val[i];
    end else begin : g_mid
      assign next_key[i] = cell_key[i+1];
      assign next_val[i] = cell_val[i+1];
    end

    okvt_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .used_i     (used[i]),
      .tail_i     (tail[i]),
      .hit_i      (hit_chain[i]),
      .next_key_i (next_key[i]),
      .next_val_i (next_val[i]),
      .hit_o      (hit_chain[i+1]),
      .first_o    (first[i]),
      .key_o      (cell_key[i]),
      .val_o      (cell_val[i])
    );
  end

  // At most one cell flags first, so OR the selected fields together
  always_comb begin
    hit_val = '0;
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) begin
        hit_val = hit_val | cell_val[i];
        hit_idx = hit_idx | okvt_pkg::idx_t'(i);
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    found_d  = 1'b0;
    rval_d   = '0;
    pos_d    = '0;
    status_d = okvt_pkg::ST_OK;
    unique case (req)
      okvt_pkg::REQ_GET: begin
        if (found) begin
          found_d = 1'b1;
          rval_d  = hit_val;
          pos_d   = hit_idx;
        end else begin
          status_d = okvt_pkg::ST_MISSING;
        end
      end
      okvt_pkg::REQ_SET, okvt_pkg::REQ_ACCESS: begin
        if (found) begin
          found_d = 1'b1;
          rval_d  = is_set ? cmd.wr_value : hit_val;
          pos_d   = hit_idx;
        end else if (full) begin
          status_d = okvt_pkg::ST_FULL;
        end else begin
          rval_d  = cmd.wr_value;
          pos_d   = okvt_pkg::idx_t'(count_q);
          count_d = count_q + okvt_pkg::cnt_t'(1);
        end
      end
      okvt_pkg::REQ_DELETE: begin
        if (found) begin
          found_d = 1'b1;
          pos_d   = hit_idx;
          count_d = count_q - okvt_pkg::cnt_t'(1);
        end else begin
          status_d = okvt_pkg::ST_MISSING;
        end
      end
      okvt_pkg::REQ_CLEAR: begin
        count_d = '0;
      end
      default: begin
        // unused codes: no operation
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q  <= found_d;
      rval_q   <= rval_d;
      pos_q    <= pos_d;
      status_q <= status_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.read_value  = okvt_pkg::RVAL_W'(rval_q);
  assign rsp_o.position    = okvt_pkg::POS_W'(pos_q);
  assign rsp_o.entry_count = okvt_pkg::ECOUNT_W'(count_q);
  assign rsp_o.status      = status_q;

endmodule

@@ tb/tb_ordered_key_value_table_top.sv @@
// Testbench for ordered_key_value_table_top: drives requests, predicts each
// response from a local copy of the table, and checks every response field.
// Depends on okvt_pkg, okvt_req_if, okvt_rsp_if and the top level RTL.
module tb_ordered_key_value_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [okvt_pkg::REQ_W-1:0] req_code_t;

  localparam req_code_t REQ_SPARE_LO = 3'd5;
  localparam req_code_t REQ_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT  = 2000;
  localparam int KEY_POOL_LEN = 24;
  localparam int IDLE_PCT     = 36;

  typedef struct packed {
    req_code_t        req_type;
    okvt_pkg::key_t   key;
    okvt_pkg::value_t write_value;
  } kv_req_t;

  typedef struct packed {
    logic                          found;
    okvt_pkg::value_t              read_value;
    logic [okvt_pkg::POS_W-1:0]    position;
    logic [okvt_pkg::ECOUNT_W-1:0] entry_count;
    logic [okvt_pkg::STATUS_W-1:0] status;
  } kv_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  okvt_req_if req_if ();
  okvt_rsp_if rsp_if ();

  ordered_key_value_table_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  kv_req_t        pending_reqs[$];
  kv_rsp_t        expected_rsps[$];
  okvt_pkg::key_t key_pool[KEY_POOL_LEN];

  // Local copy of the table
  okvt_pkg::key_t   shadow_keys[okvt_pkg::TABLE_DEPTH];
  okvt_pkg::value_t shadow_values[okvt_pkg::TABLE_DEPTH];
  int               shadow_used;

  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  req_took = 1'b0;
  bit  calm = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic kv_rsp_t apply_request(input kv_req_t r);
    kv_rsp_t res;
    int      hit;
    int      i;
    res = '0;
    res.status = okvt_pkg::ST_OK;
    hit = -1;
    for (i = 0; i < shadow_used; i++) begin
      if (hit < 0 && shadow_keys[i] == r.key) hit = i;
    end
    case (r.req_type)
      okvt_pkg::REQ_GET: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          res.read_value = shadow_values[hit];
          res.position = hit[okvt_pkg::POS_W-1:0];
        end else begin
          res.status = okvt_pkg::ST_MISSING;
        end
      end
      okvt_pkg::REQ_SET, okvt_pkg::REQ_ACCESS: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          if (r.req_type == okvt_pkg::REQ_SET) shadow_values[hit] = r.write_value;
          res.read_value = shadow_values[hit];
          res.position = hit[okvt_pkg::POS_W-1:0];
        end else if (shadow_used >= okvt_pkg::TABLE_DEPTH) begin
          res.status = okvt_pkg::ST_FULL;
        end else begin
          shadow_keys[shadow_used] = r.key;
          shadow_values[shadow_used] =
            (r.req_type == okvt_pkg::REQ_SET) ? r.write_value : '0;
          res.read_value = shadow_values[shadow_used];
          res.position = shadow_used[okvt_pkg::POS_W-1:0];
          shadow_used++;
        end
      end
      okvt_pkg::REQ_DELETE: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          res.position = hit[okvt_pkg::POS_W-1:0];
          for (i = hit; i + 1 < shadow_used; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_values[i] = shadow_values[i+1];
          end
          shadow_used--;
        end else begin
          res.status = okvt_pkg::ST_MISSING;
        end
      end
      okvt_pkg::REQ_CLEAR: shadow_used = 0;
      default: ;
    endcase
    res.entry_count = shadow_used[okvt_pkg::ECOUNT_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] expv, actv);
    if (expv !== actv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      mismatches++;
    end
  endtask

  function automatic void push_req(input req_code_t op, input okvt_pkg::key_t k,
                                   input okvt_pkg::value_t v);
    kv_req_t r;
    r.req_type = op;
    r.key = k;
    r.write_value = v;
    pending_reqs.push_back(r);
  endfunction

  // Keys mostly come from a small pool so that hits, shifts and a full table are common
  function automatic void push_random_reqs(input int count);
    int             roll;
    req_code_t      op;
    okvt_pkg::key_t k;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 24)      op = okvt_pkg::REQ_GET;
      else if (roll < 50) op = okvt_pkg::REQ_SET;
      else if (roll < 66) op = okvt_pkg::REQ_ACCESS;
      else if (roll < 86) op = okvt_pkg::REQ_DELETE;
      else if (roll < 89) op = okvt_pkg::REQ_CLEAR;
      else if (roll < 92) op = REQ_SPARE_LO +
                               req_code_t'($urandom_range(REQ_SPARE_HI - REQ_SPARE_LO));
      else                op = req_code_t'($urandom_range(REQ_SPARE_HI));
      if ($urandom_range(99) < 85) k = key_pool[$urandom_range(KEY_POOL_LEN - 1)];
      else                         k = $urandom;
      push_req(op, k, $urandom);
    end
  endfunction

  // Driver: advance on a taken transaction, idle at random outside calm stretches
  always @(negedge clk_i) begin
    kv_req_t nxt;
    if (rst_ni) begin
      if (!req_if.valid || req_took) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_reqs.pop_front();
          req_if.valid       <= 1'b1;
          req_if.req_type    <= nxt.req_type;
          req_if.key         <= nxt.key;
          req_if.write_value <= nxt.write_value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on each request, check each response, watch for a hang
  always @(posedge clk_i) begin
    kv_req_t got_req;
    kv_rsp_t exp_rsp;
    bit      rsp_took;
    if (!rst_ni) begin
      req_took = 1'b0;
      quiet_cycles = 0;
    end else begin
      req_took = req_if.valid && req_if.ready;
      rsp_took = rsp_if.valid && rsp_if.ready;
      if (rsp_took) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          mismatches++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          check_field("found", exp_rsp.found, rsp_if.found);
          check_field("read_value", exp_rsp.read_value, rsp_if.read_value);
          check_field("position", exp_rsp.position, rsp_if.position);
          check_field("entry_count", exp_rsp.entry_count, rsp_if.entry_count);
          check_field("status", exp_rsp.status, rsp_if.status);
        end
      end
      if (req_took) begin
        got_req.req_type = req_if.req_type;
        got_req.key = req_if.key;
        got_req.write_value = req_if.write_value;
        expected_rsps.push_back(apply_request(got_req));
      end
      if (req_took || rsp_took) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ordered_key_value_table_top verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
      @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = okvt_pkg::REQ_GET;
    req_if.key = '0;
    req_if.write_value = '0;
    rsp_if.ready = 1'b0;
    shadow_used = 0;
    for (int i = 0; i < KEY_POOL_LEN; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    // Directed: edge keys and values, shift on delete, spare code, full table
    push_req(okvt_pkg::REQ_GET, '0, '0);
    push_req(okvt_pkg::REQ_SET, '0, '1);
    push_req(okvt_pkg::REQ_ACCESS, '1, '1);
    push_req(okvt_pkg::REQ_SET, '1, 32'h5a5a_a5a5);
    push_req(okvt_pkg::REQ_DELETE, '0, '0);
    push_req(okvt_pkg::REQ_DELETE, 32'h0000_1234, '0);
    push_req(REQ_SPARE_HI, '1, '1);
    for (int i = 1; i <= okvt_pkg::TABLE_DEPTH - 1; i++)
      push_req(okvt_pkg::REQ_SET, okvt_pkg::key_t'(i), okvt_pkg::value_t'(~i));
    push_req(okvt_pkg::REQ_SET, 32'hdead_beef, '1);
    push_req(okvt_pkg::REQ_ACCESS, 32'hdead_beef, '0);
    push_req(okvt_pkg::REQ_CLEAR, '1, '1);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Hold off until the directed part has fully drained
    wait_drained();
    @(posedge clk_i);
    push_random_reqs(350);
    while (pending_reqs.size() > 0) @(negedge clk_i);
    @(posedge clk_i);
    calm = 1'b1;
    push_random_reqs(300);
    while (pending_reqs.size() > 0) @(negedge clk_i);
    @(posedge clk_i);
    calm = 1'b0;
    push_random_reqs(375);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (expected_rsps.size() != 0) begin
      $error("%0d responses never arrived", expected_rsps.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ordered_key_value_table_top verification clean");
    end else begin
      $display("ordered_key_value_table_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/okvt_pkg.sv
hw/rtl/okvt_req_if.sv
hw/rtl/okvt_rsp_if.sv
hw/rtl/okvt_cell.sv
hw/rtl/ordered_key_value_table_top.sv
tb/tb_ordered_key_value_table_top.sv
